// ===== src/spd_pkg.sv =====
`default_nettype none

package spd_pkg;

   // Register map of the configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int NUM_REGS    = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_SVC_LEVEL0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SVC_LEVEL1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SVC_LEVEL2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SVC_LEVEL3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SVC_LEVEL4 = 3'd4;

   localparam logic [7:0] SVC_RESET [NUM_REGS] = '{8'd2, 8'd2, 8'd5, 8'd10, 8'd20};

   typedef struct packed {
      logic        arrival_valid;
      logic [15:0] job_id;
      logic [2:0]  job_priority;
   } spd_req_type;

   typedef struct packed {
      logic        server_index;
      logic        server_busy;
      logic [7:0]  time_left;
      logic        assigned;
      logic [15:0] assigned_id;
      logic [2:0]  assigned_priority;
      logic [31:0] wait_ticks;
      logic        arrival_dropped;
      logic        all_idle;
      logic        last_result;
   } spd_rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // latch the request word, clear per-tick flags
      logic enqueue;   // append the arrival to its level queue
      logic serve;     // handle the current server
      logic commit;    // finish a dispatch with the queue read data
      logic send;      // a response word was taken
   } spd_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic needs_read;   // current server is free and a queue holds a job
      logic last_server;  // server counter is at the last server
   } spd_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_SERVE,
      ST_FETCH,
      ST_SEND
   } spd_state_type;

endpackage

`default_nettype wire

// ===== src/spd_ctrl.sv =====
`default_nettype none

module spd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire spd_pkg::spd_status_type status,
   output spd_pkg::spd_cmd_type     cmd
);
   import spd_pkg::*;

   spd_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_ENQ;
         end
         ST_ENQ: state_in = ST_SERVE;
         ST_SERVE: begin
            if (status.needs_read) state_in = ST_FETCH;
            else if (status.last_server) state_in = ST_SEND;
         end
         ST_FETCH: begin
            state_in = status.last_server ? ST_SEND : ST_SERVE;
         end
         ST_SEND: begin
            if (rsp_ready && status.last_server) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ENQ:   cmd.enqueue = 1'b1;
         ST_SERVE: cmd.serve   = 1'b1;
         ST_FETCH: cmd.commit  = 1'b1;
         ST_SEND: begin
            rsp_valid = 1'b1;
            cmd.send  = rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/spd_datapath.sv =====
`default_nettype none

module spd_datapath #(
   parameter int NUM_SERVERS = 2,
   parameter int NUM_LEVELS  = 5,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire spd_pkg::spd_req_type                 req_data,
   output spd_pkg::spd_rsp_type                      rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [spd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [7:0]                           csr_wdata,
   input  wire spd_pkg::spd_cmd_type                 cmd,
   output spd_pkg::spd_status_type                   status
);
   import spd_pkg::*;

   localparam int HW   = $clog2(QUEUE_DEPTH);
   localparam int FW   = $clog2(QUEUE_DEPTH + 1);
   localparam int SUMW = HW + 1;
   localparam int LW   = $clog2(NUM_LEVELS);
   localparam int SW   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int MEMD = NUM_LEVELS * QUEUE_DEPTH;
   localparam int AW   = $clog2(MEMD);

   typedef struct packed {
      logic [15:0] id;
      logic [31:0] stamp;
   } entry_type;

   spd_req_type  in_ff, in_in;
   logic [7:0]   svc_ff [NUM_REGS];
   logic [7:0]   svc_in [NUM_REGS];
   logic [31:0]  tick_ff, tick_in;
   logic [HW-1:0] head_ff [NUM_LEVELS];
   logic [HW-1:0] head_in [NUM_LEVELS];
   logic [FW-1:0] fill_ff [NUM_LEVELS];
   logic [FW-1:0] fill_in [NUM_LEVELS];
   logic [7:0]   time_ff [NUM_SERVERS];
   logic [7:0]   time_in [NUM_SERVERS];
   spd_rsp_type  res_ff [NUM_SERVERS];
   spd_rsp_type  res_in [NUM_SERVERS];
   logic [SW-1:0] srv_ff, srv_in;
   logic [LW-1:0] pick_ff, pick_in;
   logic         dropped_ff, dropped_in;
   logic         active_ff, active_in;

   entry_type    mem_ff [MEMD];
   entry_type    rd_ff;

   // combinational helpers
   logic          found;
   logic [LW-1:0] lev;
   logic [7:0]    cur_time;
   logic [SW-1:0] srv_next;
   logic          last_srv;
   logic          in_range;
   logic [HW-1:0] enq_head;
   logic [FW-1:0] enq_fill;
   logic          enq_ok;
   logic [LW-1:0] enq_lev;
   logic [SUMW-1:0] slot_sum;
   logic [HW-1:0] slot;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          mem_we, mem_re;
   logic [HW-1:0] head_next;
   spd_rsp_type   rec;

   assign csr_ready = 1'b1;

   // Highest non-empty level; ascending scan, last hit wins.
   always_comb begin
      found = 1'b0;
      lev   = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (fill_ff[l] != '0) begin
            found = 1'b1;
            lev   = LW'(l);
         end
      end
   end

   always_comb begin
      enq_head = '0;
      enq_fill = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (in_ff.job_priority == 3'(l)) begin
            enq_head = head_ff[l];
            enq_fill = fill_ff[l];
         end
      end
   end

   assign cur_time = time_ff[srv_ff];
   assign last_srv = (srv_ff == SW'(NUM_SERVERS - 1));
   assign srv_next = last_srv ? '0 : srv_ff + 1'b1;

   assign status.needs_read  = (cur_time == 8'd0) && found;
   assign status.last_server = last_srv;

   assign in_range = (in_ff.job_priority < 3'(NUM_LEVELS));
   assign enq_ok   = in_ff.arrival_valid && in_range && (enq_fill != FW'(QUEUE_DEPTH));
   assign enq_lev  = in_ff.job_priority[LW-1:0];
   assign slot_sum = SUMW'(enq_head) + SUMW'(enq_fill);
   assign slot     = (slot_sum >= SUMW'(QUEUE_DEPTH)) ?
                     HW'(slot_sum - SUMW'(QUEUE_DEPTH)) : HW'(slot_sum);
   assign wr_addr  = AW'(enq_lev) * AW'(QUEUE_DEPTH) + AW'(slot);
   assign rd_addr  = AW'(lev) * AW'(QUEUE_DEPTH) + AW'(head_ff[lev]);
   assign head_next = (head_ff[lev] == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff[lev] + 1'b1;
   assign mem_we   = cmd.enqueue && enq_ok;
   assign mem_re   = cmd.serve && status.needs_read;

   always_comb begin
      in_in      = in_ff;
      svc_in     = svc_ff;
      tick_in    = tick_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      time_in    = time_ff;
      res_in     = res_ff;
      srv_in     = srv_ff;
      pick_in    = pick_ff;
      dropped_in = dropped_ff;
      active_in  = active_ff;
      rec        = '0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SVC_LEVEL0: svc_in[0] = csr_wdata;
            REG_SVC_LEVEL1: svc_in[1] = csr_wdata;
            REG_SVC_LEVEL2: svc_in[2] = csr_wdata;
            REG_SVC_LEVEL3: svc_in[3] = csr_wdata;
            REG_SVC_LEVEL4: svc_in[4] = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         in_in      = req_data;
         dropped_in = 1'b0;
         active_in  = 1'b0;
      end

      if (cmd.enqueue) begin
         dropped_in = in_ff.arrival_valid && !enq_ok;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (enq_ok && in_ff.job_priority == 3'(l)) fill_in[l] = fill_ff[l] + 1'b1;
         end
      end

      if (cmd.serve) begin
         if (cur_time != 8'd0) begin
            time_in[srv_ff] = cur_time - 8'd1;
            rec.server_busy = 1'b1;
            rec.time_left   = cur_time - 8'd1;
            res_in[srv_ff]  = rec;
            active_in       = 1'b1;
            srv_in          = srv_next;
            if (last_srv) tick_in = tick_ff + 32'd1;
         end else if (found) begin
            head_in[lev] = head_next;
            fill_in[lev] = fill_ff[lev] - 1'b1;
            pick_in      = lev;
         end else begin
            res_in[srv_ff] = rec;
            srv_in         = srv_next;
            if (last_srv) tick_in = tick_ff + 32'd1;
         end
      end

      if (cmd.commit) begin
         time_in[srv_ff]       = svc_ff[pick_ff];
         rec.time_left         = svc_ff[pick_ff];
         rec.assigned          = 1'b1;
         rec.assigned_id       = rd_ff.id;
         rec.assigned_priority = 3'(pick_ff);
         rec.wait_ticks        = tick_ff - rd_ff.stamp;
         res_in[srv_ff]        = rec;
         active_in             = 1'b1;
         srv_in                = srv_next;
         if (last_srv) tick_in = tick_ff + 32'd1;
      end

      if (cmd.send) srv_in = srv_next;
   end

   always_comb begin
      rsp_data                 = res_ff[srv_ff];
      rsp_data.server_index    = srv_ff[0];
      rsp_data.arrival_dropped = dropped_ff;
      rsp_data.all_idle        = !active_ff;
      rsp_data.last_result     = last_srv;
   end

   // queue memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[wr_addr] <= '{id: in_ff.job_id, stamp: tick_ff};
      if (mem_re) rd_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      res_ff  <= res_in;
      pick_ff <= pick_in;
      if (reset) begin
         svc_ff     <= SVC_RESET;
         tick_ff    <= '0;
         srv_ff     <= '0;
         dropped_ff <= 1'b0;
         active_ff  <= 1'b0;
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
         for (int s = 0; s < NUM_SERVERS; s++) time_ff[s] <= '0;
      end else begin
         svc_ff     <= svc_in;
         tick_ff    <= tick_in;
         srv_ff     <= srv_in;
         dropped_ff <= dropped_in;
         active_ff  <= active_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         time_ff    <= time_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/strict_priority_multi_server_dispatch.sv =====
// A request word is taken in the idle state and enqueued in the enqueue state, then each
// server is handled in turn: counting down or idle in the serve state alone, or dispatched
// through the registered queue read (serve, then fetch). Response words follow one per cycle
// while rsp_ready is high, NUM_SERVERS of them; req_ready is low until the last one is taken.
// Reset (synchronous, active high) clears tick count, queue pointers and server timers,
// and loads the service times 2, 2, 5, 10, 20. Queue memory is not cleared.
`default_nettype none

module strict_priority_multi_server_dispatch #(
   parameter int NUM_SERVERS = 2,
   parameter int NUM_LEVELS  = 5,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel: one tick per word
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire spd_pkg::spd_req_type            req_data,
   // response channel: one word per server per tick
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output spd_pkg::spd_rsp_type                 rsp_data,
   // configuration writes, service time per level
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [spd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_wdata
);
   import spd_pkg::*;

   spd_cmd_type    cmd;
   spd_status_type status;

   // Sequencer: accept, enqueue, walk the servers, then drain the response words.
   spd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Queues, server timers, tick counter and the per-server response buffer.
   spd_datapath #(
      .NUM_SERVERS (NUM_SERVERS),
      .NUM_LEVELS  (NUM_LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== bench/strict_priority_multi_server_dispatch_tb.sv =====
`timescale 1ns / 1ps

module strict_priority_multi_server_dispatch_tb;
   import spd_pkg::*;

   localparam int NUM_SERVERS = 2;
   localparam int NUM_LEVELS  = 5;
   localparam int QUEUE_DEPTH = 16;

   // csr map: one register per level, and the unused indexes above them
   localparam logic [CSR_INDEX_W-1:0] LEVEL_REGS [NUM_REGS] = '{
      REG_SVC_LEVEL0, REG_SVC_LEVEL1, REG_SVC_LEVEL2, REG_SVC_LEVEL3, REG_SVC_LEVEL4
   };
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE5 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE7 = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] SPARE_REGS [3] = '{REG_SPARE5, REG_SPARE6, REG_SPARE7};

   localparam int MAX_PRINTED = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   spd_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   spd_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = '0;

   strict_priority_multi_server_dispatch #(
      .NUM_SERVERS(NUM_SERVERS),
      .NUM_LEVELS (NUM_LEVELS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Dispatcher shadow state
   // ---------------------------------------------------------------------
   logic [31:0] tick_no;
   logic [15:0] slot_id    [NUM_LEVELS*QUEUE_DEPTH];
   logic [31:0] slot_stamp [NUM_LEVELS*QUEUE_DEPTH];
   int          lvl_head   [NUM_LEVELS];
   int          lvl_fill   [NUM_LEVELS];
   logic [7:0]  busy_left  [NUM_SERVERS];
   logic [7:0]  svc_time   [NUM_REGS];

   // server status words still owed by the DUT, oldest first
   spd_rsp_type server_reports [$];

   int mismatch_count = 0;
   int words_checked  = 0;
   int burst_left     = 0;
   int spare_pick     = 0;

   task automatic clear_shadow();
      tick_no = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         lvl_head[l] = 0;
         lvl_fill[l] = 0;
      end
      for (int s = 0; s < NUM_SERVERS; s++) busy_left[s] = '0;
      for (int r = 0; r < NUM_REGS; r++) svc_time[r] = SVC_RESET[r];
   endtask

   // One tick: enqueue the arrival, then walk the servers in index order.
   task automatic advance_tick(input spd_req_type w);
      spd_rsp_type word;
      spd_rsp_type batch [NUM_SERVERS];
      int          lvl;
      int          at;
      logic        dropped;
      logic        active;
      logic        found;
      dropped = 1'b0;
      active  = 1'b0;
      lvl     = int'(w.job_priority);
      if (w.arrival_valid) begin
         if (lvl >= NUM_LEVELS) begin
            dropped = 1'b1;              // no such level
         end else if (lvl_fill[lvl] >= QUEUE_DEPTH) begin
            dropped = 1'b1;              // level FIFO full
         end else begin
            at = lvl * QUEUE_DEPTH + (lvl_head[lvl] + lvl_fill[lvl]) % QUEUE_DEPTH;
            slot_id[at]    = w.job_id;
            slot_stamp[at] = tick_no;
            lvl_fill[lvl]++;
         end
      end
      for (int s = 0; s < NUM_SERVERS; s++) begin
         word = '0;
         word.server_index = s[0];
         if (busy_left[s] != 8'd0) begin
            // counting down; reaching zero here still blocks a new job this tick
            busy_left[s]--;
            word.server_busy = 1'b1;
         end else begin
            found = 1'b0;
            for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
               if (!found && lvl_fill[l] != 0) begin
                  at = l * QUEUE_DEPTH + lvl_head[l];
                  word.assigned          = 1'b1;
                  word.assigned_id       = slot_id[at];
                  word.assigned_priority = 3'(l);
                  word.wait_ticks        = tick_no - slot_stamp[at];
                  lvl_head[l]  = (lvl_head[l] + 1) % QUEUE_DEPTH;
                  lvl_fill[l]--;
                  busy_left[s] = svc_time[l];
                  found        = 1'b1;
               end
            end
         end
         active = active | word.server_busy | word.assigned;
         word.time_left       = busy_left[s];
         word.arrival_dropped = dropped;
         word.last_result     = (s == NUM_SERVERS - 1);
         batch[s] = word;
      end
      for (int s = 0; s < NUM_SERVERS; s++) begin
         batch[s].all_idle = ~active;
         server_reports.push_back(batch[s]);
      end
      tick_no++;
   endtask

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t: word %0d %s: got %0h, want %0h",
                  $realtime, words_checked, what, got, want);
   endtask

   task automatic compare_report(input spd_rsp_type got, input spd_rsp_type want);
      if (got.server_index !== want.server_index)
         report_mismatch("server_index", 32'(got.server_index), 32'(want.server_index));
      if (got.server_busy !== want.server_busy)
         report_mismatch("server_busy", 32'(got.server_busy), 32'(want.server_busy));
      if (got.time_left !== want.time_left)
         report_mismatch("time_left", 32'(got.time_left), 32'(want.time_left));
      if (got.assigned !== want.assigned)
         report_mismatch("assigned", 32'(got.assigned), 32'(want.assigned));
      if (got.assigned_id !== want.assigned_id)
         report_mismatch("assigned_id", 32'(got.assigned_id), 32'(want.assigned_id));
      if (got.assigned_priority !== want.assigned_priority)
         report_mismatch("assigned_priority", 32'(got.assigned_priority),
                         32'(want.assigned_priority));
      if (got.wait_ticks !== want.wait_ticks)
         report_mismatch("wait_ticks", got.wait_ticks, want.wait_ticks);
      if (got.arrival_dropped !== want.arrival_dropped)
         report_mismatch("arrival_dropped", 32'(got.arrival_dropped),
                         32'(want.arrival_dropped));
      if (got.all_idle !== want.all_idle)
         report_mismatch("all_idle", 32'(got.all_idle), 32'(want.all_idle));
      if (got.last_result !== want.last_result)
         report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
   endtask

   // Every taken response word is matched against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (server_reports.size() == 0)
            report_mismatch("word with nothing owed", 32'(rsp_data.server_index), '0);
         else
            compare_report(rsp_data, server_reports.pop_front());
         words_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // Response side back-pressure: runs of ready and stall, with the odd
   // long open stretch.
   // ---------------------------------------------------------------------
   int ready_run = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run <= 0;
      end else if (ready_run == 0) begin
         case ($urandom_range(0, 9))
            0: begin
               rsp_ready <= 1'b1;
               ready_run <= $urandom_range(50, 200);
            end
            1, 2, 3: begin
               rsp_ready <= 1'b0;
               ready_run <= $urandom_range(0, 7);
            end
            default: begin
               rsp_ready <= 1'b1;
               ready_run <= $urandom_range(0, 11);
            end
         endcase
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Send one tick word. Words go out in bursts; at a burst boundary valid
   // drops for a random gap (sometimes none, so bursts also run together).
   // Valid stays high after acceptance so a following word in the burst
   // needs no toggle.
   task automatic send_tick(input logic arrive, input logic [15:0] id,
                            input logic [2:0] prio);
      spd_req_type w;
      int          gap;
      w.arrival_valid = arrive;
      w.job_id        = id;
      w.job_priority  = prio;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      advance_tick(w);
   endtask

   // Stop sending and wait until every owed word has been taken.
   task automatic drain_reports();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (server_reports.size() != 0) @(posedge clock);
   endtask

   // One csr write; valid is left high for a following write.
   task automatic put_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_REGS) svc_time[idx] = val;   // spare indexes are ignored
   endtask

   // Reprogram all service times with the block idle; one spare index is
   // hit each time as well, with random data, and must change nothing.
   task automatic program_levels(input logic [NUM_REGS-1:0][7:0] times);
      drain_reports();
      put_csr(SPARE_REGS[spare_pick], 8'($urandom));
      spare_pick = (spare_pick + 1) % 3;
      for (int i = 0; i < NUM_REGS; i++) put_csr(LEVEL_REGS[i], times[i]);
      csr_valid <= 1'b0;
   endtask

   // Random ticks: mostly legal levels, a tenth out of range.
   task automatic random_ticks(input int count, input int arrive_pct);
      logic [2:0] prio;
      for (int n = 0; n < count; n++) begin
         prio = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, NUM_LEVELS - 1));
         send_tick($urandom_range(0, 99) < arrive_pct, 16'($urandom), prio);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset service times; strict priority, same-tick dispatch, finishing server.
   task automatic test_priority_order();
      send_tick(1'b0, 16'hFFFF, 3'd7);   // no arrival: junk fields, no drop
      send_tick(1'b1, 16'h0000, 3'd0);   // dispatched on arrival, wait 0
      send_tick(1'b1, 16'hFFFF, 3'd4);   // server 1 takes the top level
      send_tick(1'b1, 16'hA5A5, 3'd2);   // server 0 hits zero, takes nothing
      send_tick(1'b1, 16'h5A5A, 3'd3);   // level 3 jumps ahead of level 2
      send_tick(1'b1, 16'h1234, 3'd1);
      repeat (3) send_tick(1'b0, 16'h0000, 3'd0);
   endtask

   // Levels past the last one are flagged as dropped.
   task automatic test_invalid_levels();
      send_tick(1'b1, 16'h8001, 3'd5);
      send_tick(1'b1, 16'h4002, 3'd6);
      send_tick(1'b1, 16'h2003, 3'd7);
      send_tick(1'b1, 16'h7FFE, 3'd4);
   endtask

   // All service times zero: a server is free again on the next tick.
   task automatic test_zero_service_time();
      program_levels('0);
      send_tick(1'b1, 16'h0F0F, 3'd0);
      send_tick(1'b1, 16'hF0F0, 3'd4);
      send_tick(1'b1, 16'h3C3C, 3'd2);
      send_tick(1'b0, 16'h0000, 3'd0);
      send_tick(1'b1, 16'hC3C3, 3'd1);
      send_tick(1'b1, 16'h6666, 3'd3);
      send_tick(1'b0, 16'h0000, 3'd0);
   endtask

   // Short random service times, moderate load.
   task automatic test_short_service_traffic();
      logic [NUM_REGS-1:0][7:0] times;
      for (int i = 0; i < NUM_REGS; i++) times[i] = 8'($urandom_range(0, 6));
      program_levels(times);
      random_ticks(300, 60);
   endtask

   // Longest service times under heavy load: FIFOs fill and arrivals drop.
   task automatic test_queue_overflow();
      program_levels({NUM_REGS{8'hFF}});
      random_ticks(150, 90);
   endtask

   // One tick of service: the backlog left by the overflow test drains.
   task automatic test_unit_service_drain();
      program_levels({NUM_REGS{8'd1}});
      random_ticks(300, 50);
   endtask

   // Random service times over a wider span.
   task automatic test_wide_service_traffic();
      logic [NUM_REGS-1:0][7:0] times;
      for (int i = 0; i < NUM_REGS; i++) times[i] = 8'($urandom_range(0, 40));
      program_levels(times);
      random_ticks(250, 75);
   endtask

   // Back to the reset values, with a full pause in the middle.
   task automatic test_reset_service_traffic();
      logic [NUM_REGS-1:0][7:0] times;
      for (int i = 0; i < NUM_REGS; i++) times[i] = SVC_RESET[i];
      program_levels(times);
      random_ticks(150, 70);
      drain_reports();                   // sender holds off until all words are in
      random_ticks(150, 70);
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      int wait_cycles;
      clear_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_priority_order();
      test_invalid_levels();
      test_zero_service_time();
      test_short_service_traffic();
      test_queue_overflow();
      test_unit_service_drain();
      test_wide_service_traffic();
      test_reset_service_traffic();

      // let the last ticks finish, bounded
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (server_reports.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (server_reports.size() != 0)
         report_mismatch("words never delivered", 32'(server_reports.size()), '0);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== strict_priority_multi_server_dispatch.f =====
src/spd_pkg.sv
src/spd_ctrl.sv
src/spd_datapath.sv
src/strict_priority_multi_server_dispatch.sv
bench/strict_priority_multi_server_dispatch_tb.sv
